// ===== sv/sti_pkg.sv =====
package sti_pkg;
    localparam int NUM_CFG = 6;
    localparam logic [2:0] REG_SX = 3'd0;
    localparam logic [2:0] REG_SY = 3'd1;
    localparam logic [2:0] REG_SZ = 3'd2;
    localparam logic [2:0] REG_EX = 3'd3;
    localparam logic [2:0] REG_EY = 3'd4;
    localparam logic [2:0] REG_EZ = 3'd5;
endpackage

// ===== sv/segment_triangle_intersect.sv =====
// Moller-Trumbore segment/triangle test in exact integer arithmetic. The segment
// is held in six APB registers (start x,y,z at 0x00..0x08, end x,y,z at 0x0C..0x14);
// write them only while the block is idle. Triangles arrive on the slave stream,
// nine signed COORD_BITS coordinates packed A.xyz, B.xyz, C.xyz from bit 0 up; one
// result per triangle leaves on the master stream in order. The pipeline accepts
// one triangle every cycle while the master stream is not stalled; the restoring
// divider forms the fraction one quotient bit per stage. Cross-product and
// dot-product stages use one multiplier layer per register stage.
module segment_triangle_intersect
    import sti_pkg::*;
#(
    parameter int COORD_BITS    = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // vert_a_x, vert_a_y, vert_a_z, vert_b_x, ..., vert_c_z (lowest first)
    input  logic [((9*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // hit, hit_fraction (lowest first)
    output logic [((FRACTION_BITS+9)/8)*8-1:0] m_axis_tdata,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [4:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    localparam int CB  = COORD_BITS;
    localparam int DB  = CB + 1;          // differences
    localparam int PB  = 2*DB + 1;        // cross components
    localparam int WB  = PB + DB + 2;     // dot products
    localparam int NS  = FRACTION_BITS;   // divider stages
    localparam int LAT = NS + 6;
    localparam int OW  = ((FRACTION_BITS+9)/8)*8;

    typedef logic signed [DB-1:0] t_d;
    typedef logic signed [PB-1:0] t_p;
    typedef logic signed [WB-1:0] t_w;

    logic signed [CB-1:0] r_cfg [NUM_CFG];
    logic [2:0] w_idx;
    assign w_idx = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CFG; i++) r_cfg[i] <= '0;
        end else if (psel && penable && pwrite && (w_idx < 3'(NUM_CFG))) begin
            r_cfg[w_idx] <= pwdata[CB-1:0];
        end
    end
    always_comb begin
        prdata = '0;
        if (w_idx < 3'(NUM_CFG)) prdata = 32'(signed'(r_cfg[w_idx]));
    end

    // pipeline control: global enable
    logic       w_en;
    logic [LAT-1:0] r_vld;
    assign w_en = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_en) r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
    end

    // stage 1: differences
    t_d r_e1 [3], r_e2 [3], r_tv [3], r_dir [3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_e1[k]  <= DB'(signed'(s_axis_tdata[(3+k)*CB +: CB]))
                          - DB'(signed'(s_axis_tdata[k*CB +: CB]));
                r_e2[k]  <= DB'(signed'(s_axis_tdata[(6+k)*CB +: CB]))
                          - DB'(signed'(s_axis_tdata[k*CB +: CB]));
                r_tv[k]  <= DB'(r_cfg[k]) - DB'(signed'(s_axis_tdata[k*CB +: CB]));
                r_dir[k] <= DB'(r_cfg[3+k]) - DB'(r_cfg[k]);
            end
        end
    end

    // stage 2: cross products pv = dir x e2, qv = tv x e1
    t_p r_pv [3], r_qv [3];
    t_d r2_e1 [3], r2_e2 [3], r2_tv [3], r2_dir [3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_pv[k] <= PB'(r_dir[(k+1)%3] * r_e2[(k+2)%3])
                         - PB'(r_dir[(k+2)%3] * r_e2[(k+1)%3]);
                r_qv[k] <= PB'(r_tv[(k+1)%3] * r_e1[(k+2)%3])
                         - PB'(r_tv[(k+2)%3] * r_e1[(k+1)%3]);
            end
            r2_e1 <= r_e1; r2_e2 <= r_e2; r2_tv <= r_tv; r2_dir <= r_dir;
        end
    end

    // stage 3: dot products
    t_w r_det, r_un, r_vn, r_tn;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_det <= WB'(r2_e1[0]*r_pv[0]) + WB'(r2_e1[1]*r_pv[1]) + WB'(r2_e1[2]*r_pv[2]);
            r_un  <= WB'(r2_tv[0]*r_pv[0]) + WB'(r2_tv[1]*r_pv[1]) + WB'(r2_tv[2]*r_pv[2]);
            r_vn  <= WB'(r2_dir[0]*r_qv[0]) + WB'(r2_dir[1]*r_qv[1])
                   + WB'(r2_dir[2]*r_qv[2]);
            r_tn  <= WB'(r2_e2[0]*r_qv[0]) + WB'(r2_e2[1]*r_qv[1]) + WB'(r2_e2[2]*r_qv[2]);
        end
    end

    // stage 4: sign normalise
    t_w r_d4, r_u4, r_v4, r_t4;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_det < 0) begin
                r_d4 <= -r_det; r_u4 <= -r_un; r_v4 <= -r_vn; r_t4 <= -r_tn;
            end else begin
                r_d4 <= r_det; r_u4 <= r_un; r_v4 <= r_vn; r_t4 <= r_tn;
            end
        end
    end

    // stage 5: bound checks
    logic r_hit5, r_eq5;
    t_w   r_d5, r_t5;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit5 <= (r_d4 > 0) && (r_u4 >= 0) && (r_u4 <= r_d4) && (r_v4 >= 0)
                   && (r_v4 <= r_d4 - r_u4) && (r_t4 >= 0) && (r_t4 <= r_d4);
            r_eq5  <= (r_t4 == r_d4);
            r_d5   <= r_d4;
            r_t5   <= r_t4;
        end
    end

    // divider stages: one quotient bit each
    t_w               r_rem [1:NS];
    t_w               r_dv  [1:NS];
    logic [NS-1:0]    r_q   [1:NS];
    logic             r_hq  [1:NS];
    logic             r_eq  [1:NS];
    for (genvar g = 0; g < NS; g++) begin : g_div
        t_w            w_rin, w_din, w_sh;
        logic [NS-1:0] w_qin;
        logic          w_hin, w_ein;
        if (g == 0) begin : g_src
            assign w_rin = r_t5;
            assign w_din = r_d5;
            assign w_qin = '0;
            assign w_hin = r_hit5;
            assign w_ein = r_eq5;
        end else begin : g_src
            assign w_rin = r_rem[g];
            assign w_din = r_dv[g];
            assign w_qin = r_q[g];
            assign w_hin = r_hq[g];
            assign w_ein = r_eq[g];
        end
        assign w_sh = w_rin <<< 1;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv[g+1] <= w_din;
                r_hq[g+1] <= w_hin;
                r_eq[g+1] <= w_ein;
                if (w_sh >= w_din) begin
                    r_rem[g+1] <= w_sh - w_din;
                    r_q[g+1]   <= {w_qin[NS-2:0], 1'b1};
                end else begin
                    r_rem[g+1] <= w_sh;
                    r_q[g+1]   <= {w_qin[NS-2:0], 1'b0};
                end
            end
        end
    end

    // output stage
    logic              r_ohit;
    logic [NS:0]       r_ofr;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ohit <= r_hq[NS];
            if (!r_hq[NS]) r_ofr <= '0;
            else if (r_eq[NS]) r_ofr <= (NS+1)'(1) << NS;
            else r_ofr <= {1'b0, r_q[NS]};
        end
    end
    assign m_axis_tvalid = r_vld[LAT-1];
    assign m_axis_tdata  = OW'({r_ofr, r_ohit});

`ifndef ASSERT_OFF
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[NS+1:1] == '0)
        else $error("miss with nonzero fraction");
    a_frac_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[NS+1] |-> m_axis_tdata[NS:1] == '0)
        else $error("fraction above one");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");
`endif
endmodule

// ===== dv/sti_checker.sv =====
module sti_checker
    import sti_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [143:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [23:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic         pready,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output int           o_fail_count,
    output int           o_pending
);
    typedef struct packed {
        logic        hit;
        logic [16:0] frac;
    } t_crossing;

    logic signed [15:0] seg_regs [NUM_CFG];
    t_crossing crossing_q[$];

    function automatic t_crossing crossing_of(input logic [143:0] tri_bits);
        longint ax, ay, az, bx, by, bz, cx, cy, cz;
        longint e1x, e1y, e1z, e2x, e2y, e2z, dx, dy, dz, px, py, pz;
        longint tx, ty, tz, qx, qy, qz, det, un, vn, tn, q, rem;
        t_crossing r;
        ax = $signed(tri_bits[15:0]);    ay = $signed(tri_bits[31:16]);
        az = $signed(tri_bits[47:32]);   bx = $signed(tri_bits[63:48]);
        by = $signed(tri_bits[79:64]);   bz = $signed(tri_bits[95:80]);
        cx = $signed(tri_bits[111:96]);  cy = $signed(tri_bits[127:112]);
        cz = $signed(tri_bits[143:128]);
        r = '0;
        e1x = bx - ax; e1y = by - ay; e1z = bz - az;
        e2x = cx - ax; e2y = cy - ay; e2z = cz - az;
        dx = seg_regs[REG_EX] - seg_regs[REG_SX];
        dy = seg_regs[REG_EY] - seg_regs[REG_SY];
        dz = seg_regs[REG_EZ] - seg_regs[REG_SZ];
        px = dy * e2z - dz * e2y; py = dz * e2x - dx * e2z; pz = dx * e2y - dy * e2x;
        det = e1x * px + e1y * py + e1z * pz;
        if (det == 0)
            return r;
        tx = seg_regs[REG_SX] - ax; ty = seg_regs[REG_SY] - ay; tz = seg_regs[REG_SZ] - az;
        qx = ty * e1z - tz * e1y; qy = tz * e1x - tx * e1z; qz = tx * e1y - ty * e1x;
        un = tx * px + ty * py + tz * pz;
        vn = dx * qx + dy * qy + dz * qz;
        tn = e2x * qx + e2y * qy + e2z * qz;
        if (det < 0) begin
            det = -det; un = -un; vn = -vn; tn = -tn;
        end
        if (un < 0 || un > det || vn < 0 || vn > det - un || tn < 0 || tn > det)
            return r;
        // long division keeps the remainder below det, so nothing overflows
        q = 0;
        rem = tn;
        if (tn == det)
            q = 65536;
        else
            for (int i = 0; i < 16; i++) begin
                rem = rem * 2;
                q = q * 2;
                if (rem >= det) begin
                    rem = rem - det;
                    q = q + 1;
                end
            end
        r.hit = 1'b1;
        r.frac = q[16:0];
        return r;
    endfunction

    assign o_pending = crossing_q.size();

    always @(posedge i_clk) begin
        t_crossing got, want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CFG; i++)
                seg_regs[i] <= '0;
            crossing_q.delete();
            o_fail_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[4:2] < NUM_CFG)
                seg_regs[paddr[4:2]] <= pwdata[15:0];
            if (s_tvalid && s_tready)
                crossing_q.push_back(crossing_of(s_tdata));
            if (m_tvalid && m_tready) begin
                got.hit = m_tdata[0];
                got.frac = m_tdata[17:1];
                if (crossing_q.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none, actual %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = crossing_q.pop_front();
                    if (got.hit !== want.hit || got.frac !== want.frac) begin
                        $display("%0t: expected hit=%b frac=%0d, actual hit=%b frac=%0d",
                                 $time, want.hit, want.frac, got.hit, got.frac);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== dv/tb.sv =====
module tb
    import sti_pkg::*;
();

    localparam int LIMIT = 400000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid, s_axis_tready;
    logic [143:0] s_axis_tdata;
    logic         m_axis_tvalid, m_axis_tready;
    logic [23:0]  m_axis_tdata;
    logic         psel, penable, pwrite, pready;
    logic [4:0]   paddr;
    logic [31:0]  pwdata, prdata;
    int           fail_count, pending, cycles;
    bit           hold_off;

    segment_triangle_intersect dut (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    sti_checker chk (
        .i_clk, .i_rst_n, .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
        .s_tdata(s_axis_tdata), .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
        .m_tdata(m_axis_tdata), .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("segment_triangle_intersect verification failed");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(3, 1);
        return $urandom_range(30, 4);
    endfunction

    // receiver: random stalls, one long hold-off on request
    initial begin
        int n;
        m_axis_tready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                m_axis_tready <= 0;
                repeat (200) @(posedge i_clk);
                hold_off = 0;
            end
            n = gap_len();
            if (n == 0) begin
                m_axis_tready <= 1;
                @(posedge i_clk);
            end else begin
                m_axis_tready <= 0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= {{16{val[15]}}, val};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic set_segment(input logic [15:0] sx, sy, sz, ex, ey, ez);
        wait (pending == 0);
        repeat (40) @(posedge i_clk);
        reg_write(REG_SX, sx); reg_write(REG_SY, sy); reg_write(REG_SZ, sz);
        reg_write(REG_EX, ex); reg_write(REG_EY, ey); reg_write(REG_EZ, ez);
    endtask

    task automatic send_tri(input logic [143:0] t, input bit gaps);
        int n;
        n = gaps ? gap_len() : 0;
        if (n > 0) begin
            s_axis_tvalid <= 0;
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= t;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rnd_coord(input int span);
        if ($urandom_range(9) == 0)
            return 16'($urandom());
        return 16'($signed($urandom_range(2 * span)) - span);
    endfunction

    // triangle likely to be crossed: vertices scattered around a point on the segment
    function automatic logic [143:0] near_tri(input logic signed [15:0] s[6], input int span);
        logic [143:0] t;
        int f, px, py, pz;
        f = $urandom_range(16);
        px = s[0] + ((s[3] - s[0]) * f) / 16;
        py = s[1] + ((s[4] - s[1]) * f) / 16;
        pz = s[2] + ((s[5] - s[2]) * f) / 16;
        for (int v = 0; v < 3; v++) begin
            t[48*v +: 16] = 16'(px + $signed($urandom_range(2 * span)) - span);
            t[48*v+16 +: 16] = 16'(py + $signed($urandom_range(2 * span)) - span);
            t[48*v+32 +: 16] = 16'(pz + $signed($urandom_range(2 * span)) - span);
        end
        return t;
    endfunction

    initial begin
        logic signed [15:0] seg[6];
        logic [143:0] t;
        int span;
        i_rst_n = 0;
        s_axis_tvalid = 0; s_axis_tdata = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        hold_off = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: zero segment (parallel), then a z-axis segment
        send_tri('0, 0);
        send_tri({16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  16'h0000, 16'h0001, 16'h0000}, 0);
        s_axis_tvalid <= 0;
        set_segment(0, 0, -100, 0, 0, 100);
        // triangle in z=0 plane, crossing at origin (vertex, u==0, v==0)
        send_tri({16'd0, 16'd0, 16'd100, 16'd0, 16'd100, 16'd0, 16'd0, 16'd0, 16'd0}, 0);
        // plane at segment start and end, inside
        send_tri({-16'sd100, 16'd50, -16'sd50, -16'sd100, -16'sd50, 16'd50,
                  -16'sd100, -16'sd50, -16'sd50}, 0);
        send_tri({16'd100, 16'd50, -16'sd50, 16'd100, -16'sd50, 16'd50,
                  16'd100, -16'sd50, -16'sd50}, 0);
        // interior hit, a miss just past, beyond segment, opposite winding
        send_tri({16'd0, 16'd0, 16'd10, 16'd0, 16'd10, 16'd0, 16'd0, -16'sd10, -16'sd10}, 0);
        send_tri({16'd0, 16'd0, 16'd10, 16'd0, 16'd10, 16'd0, 16'd0, 16'd1, 16'd1}, 0);
        send_tri({16'd200, 16'd0, 16'd10, 16'd200, 16'd10, 16'd0, 16'd200, -16'sd9, -16'sd9}, 0);
        send_tri({16'd30, 16'd10, 16'd0, 16'd30, 16'd0, 16'd10, 16'd30, -16'sd9, -16'sd9}, 0);
        // parallel triangle
        send_tri({16'd0, 16'd0, 16'd5, 16'd5, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 0);
        // extremes
        send_tri({9{16'h7fff}}, 0);
        send_tri({9{16'h8000}}, 0);
        send_tri({16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
                  16'h8000, 16'h8000, 16'h7fff}, 0);
        s_axis_tvalid <= 0;
        set_segment(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
        send_tri({16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
                  16'h8000, 16'h8000, 16'h7fff}, 0);
        send_tri({16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff,
                  16'h7fff, 16'h7fff, 16'h8000}, 0);
        send_tri({9{16'h5555}}, 0);
        send_tri({9{16'haaaa}}, 0);

        // random phases, each with its own segment
        for (int ph = 0; ph < 8; ph++) begin
            s_axis_tvalid <= 0;
            span = (ph % 3 == 0) ? 32767 : (ph % 3 == 1) ? 2000 : 40;
            for (int k = 0; k < 6; k++)
                seg[k] = (ph == 7) ? ((k < 3) ? 16'sh7fff : 16'sh8000) : rnd_coord(span);
            set_segment(seg[0], seg[1], seg[2], seg[3], seg[4], seg[5]);
            if (ph == 2)
                hold_off = 1;
            for (int i = 0; i < 155; i++) begin
                if ($urandom_range(9) < 7)
                    t = near_tri(seg, (span > 4000) ? 16000 : span);
                else
                    for (int w = 0; w < 9; w++) t[16*w +: 16] = rnd_coord(span);
                send_tri(t, ph != 4);
            end
        end
        s_axis_tvalid <= 0;
        wait (pending == 0);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("segment_triangle_intersect verification clean");
        else
            $display("segment_triangle_intersect verification failed");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/sti_pkg.sv
sv/segment_triangle_intersect.sv
dv/sti_checker.sv
dv/tb.sv
